// ===== hw/rtl/bmf_pkg.sv =====
`default_nettype none

package bmf_pkg;

    localparam int HEIGHT_W   = 16;
    localparam int POS_W      = 6;
    localparam int SIZE_W     = 7;
    localparam int SIZE_RESET = 64;

    localparam logic MODE_FLUSH = 1'b1;

    localparam int OUT_DEPTH = 8;
    localparam int OUT_PTR_W = 3;
    localparam int OUT_CNT_W = 4;

    typedef logic [1:0] bmf_slot_t;

    localparam bmf_slot_t SLOT_FIRST = 2'd0;
    localparam bmf_slot_t SLOT_LAST  = 2'd2;

    typedef enum logic [1:0] {
        DIV3_NONE = 2'd0,
        DIV3_ONE  = 2'd1,
        DIV3_TWO  = 2'd2
    } bmf_div3_t;

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             last;
    } bmf_tag_t;

    typedef struct packed {
        logic      top_ok;
        logic      bot_ok;
        logic      left_ok;
        logic      right_ok;
        bmf_slot_t slot_top;
        bmf_slot_t slot_mid;
        bmf_slot_t slot_bot;
        bmf_tag_t  tag;
    } bmf_win_t;

    typedef struct packed {
        logic [HEIGHT_W-1:0] smoothed;
        bmf_tag_t            tag;
    } bmf_result_t;

    function automatic bmf_slot_t bmf_slot_next(input bmf_slot_t s);
        return (s == SLOT_LAST) ? SLOT_FIRST : s + 2'd1;
    endfunction

    function automatic bmf_slot_t bmf_slot_prev(input bmf_slot_t s);
        return (s == SLOT_FIRST) ? SLOT_LAST : s - 2'd1;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bmf_ram.sv =====
`default_nettype none

module bmf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_a_reg;
    logic [WIDTH-1:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_a_reg <= mem_reg[rd_addr_a];
        rd_b_reg <= mem_reg[rd_addr_b];
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/bmf_datapath.sv =====
`default_nettype none

module bmf_datapath
    import bmf_pkg::*;
#(
    parameter int MAX_SIZE = 64,
    parameter int DW       = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  bmf_slot_t                   wr_slot,
    input  logic [$clog2(MAX_SIZE)-1:0] wr_addr,
    input  logic [DW-1:0]               wr_data,
    input  logic [$clog2(MAX_SIZE)-1:0] rd_col,
    input  logic                        emit_en,
    input  bmf_win_t                    win,
    output logic                        res_valid,
    output bmf_result_t                 res
);

    localparam int AW  = $clog2(MAX_SIZE);
    localparam int CSW = DW + 2;
    localparam int SW  = DW + 4;
    localparam int KSH = SW + 4;
    localparam int PW  = SW + KSH + 1;

    localparam logic [KSH:0] RECIP_ONE   = (KSH+1)'(64'd1 << KSH);
    localparam logic [KSH:0] RECIP_THREE = (KSH+1)'(((64'd1 << KSH) + 64'd2) / 64'd3);
    localparam logic [KSH:0] RECIP_NINE  = (KSH+1)'(((64'd1 << KSH) + 64'd8) / 64'd9);

    function automatic logic [DW-1:0] pick_row(
        input bmf_slot_t     s,
        input logic [DW-1:0] d0,
        input logic [DW-1:0] d1,
        input logic [DW-1:0] d2
    );
        logic [DW-1:0] r;
        case (s)
            2'd1:    r = d1;
            2'd2:    r = d2;
            default: r = d0;
        endcase
        return r;
    endfunction

    logic [AW-1:0] rd_addr_a;
    logic [AW-1:0] rd_addr_b;
    logic [DW-1:0] rd_data [3][2];

    assign rd_addr_a = rd_col;
    assign rd_addr_b = rd_col + AW'(1);

    // three row buffers, rotated by row
    for (genvar g = 0; g < 3; g++)
    begin : g_line
        bmf_ram #(
            .WIDTH (DW),
            .DEPTH (MAX_SIZE)
        ) u_ram (
            .clk       (clk),
            .wr_en     (wr_en && (wr_slot == bmf_slot_t'(g))),
            .wr_addr   (wr_addr),
            .wr_data   (wr_data),
            .rd_addr_a (rd_addr_a),
            .rd_addr_b (rd_addr_b),
            .rd_data_a (rd_data[g][0]),
            .rd_data_b (rd_data[g][1])
        );
    end

    // stage 0: read issued, same-cycle write captured for bypass
    logic                v0_reg;
    bmf_win_t            win0_reg;
    logic [2:0][1:0]     hit0_reg;
    logic [2:0][1:0]     hit0_next;
    logic [DW-1:0]       byp0_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            hit0_next[k][0] = wr_en && (wr_slot == bmf_slot_t'(k)) && (wr_addr == rd_addr_a);
            hit0_next[k][1] = wr_en && (wr_slot == bmf_slot_t'(k)) && (wr_addr == rd_addr_b);
        end
    end

    // stage 1: column sums
    logic [DW-1:0]  tap [3][2];
    logic [CSW-1:0] cs_next [2];
    logic [1:0]     sh1_next;
    bmf_div3_t      div1_next;

    always_comb
    begin
        logic [DW-1:0] top_w;
        logic [DW-1:0] mid_w;
        logic [DW-1:0] bot_w;
        for (int k = 0; k < 3; k++)
        begin
            for (int p = 0; p < 2; p++)
            begin
                tap[k][p] = hit0_reg[k][p] ? byp0_reg : rd_data[k][p];
            end
        end
        for (int p = 0; p < 2; p++)
        begin
            top_w = pick_row(win0_reg.slot_top, tap[0][p], tap[1][p], tap[2][p]);
            mid_w = pick_row(win0_reg.slot_mid, tap[0][p], tap[1][p], tap[2][p]);
            bot_w = pick_row(win0_reg.slot_bot, tap[0][p], tap[1][p], tap[2][p]);
            cs_next[p] = (win0_reg.top_ok ? CSW'(top_w) : '0) + CSW'(mid_w)
                       + (win0_reg.bot_ok ? CSW'(bot_w) : '0);
        end
        sh1_next = {1'b0, win0_reg.top_ok ^ win0_reg.bot_ok}
                 + {1'b0, win0_reg.left_ok ^ win0_reg.right_ok};
        if (win0_reg.top_ok && win0_reg.bot_ok && win0_reg.left_ok && win0_reg.right_ok)
        begin
            div1_next = DIV3_TWO;
        end
        else if ((win0_reg.top_ok && win0_reg.bot_ok) || (win0_reg.left_ok && win0_reg.right_ok))
        begin
            div1_next = DIV3_ONE;
        end
        else
        begin
            div1_next = DIV3_NONE;
        end
    end

    logic           v1_reg;
    logic [CSW-1:0] cs_c1_reg;
    logic [CSW-1:0] cs_n1_reg;
    logic [1:0]     sh1_reg;
    bmf_div3_t      div1_reg;
    logic           left1_reg;
    logic           right1_reg;
    bmf_tag_t       tag1_reg;

    // stage 2: window sum and power-of-two part of the divide
    logic [CSW-1:0] prev_cs_reg;
    logic [SW-1:0]  sum2;
    logic [SW-1:0]  x2_next;

    always_comb
    begin
        sum2 = (left1_reg ? SW'(prev_cs_reg) : '0) + SW'(cs_c1_reg)
             + (right1_reg ? SW'(cs_n1_reg) : '0);
        x2_next = sum2 >> sh1_reg;
    end

    logic          v2_reg;
    logic [SW-1:0] x2_reg;
    bmf_div3_t     div2_reg;
    bmf_tag_t      tag2_reg;

    // stage 3: reciprocal multiply for the factors of three
    logic [KSH:0]  recip;
    logic [PW-1:0] prod3_next;

    always_comb
    begin
        case (div2_reg)
            DIV3_ONE: recip = RECIP_THREE;
            DIV3_TWO: recip = RECIP_NINE;
            default:  recip = RECIP_ONE;
        endcase
        prod3_next = PW'(x2_reg) * PW'(recip);
    end

    logic          v3_reg;
    logic [PW-1:0] prod3_reg;
    bmf_tag_t      tag3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= emit_en;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        win0_reg   <= win;
        hit0_reg   <= hit0_next;
        byp0_reg   <= wr_data;
        cs_c1_reg  <= cs_next[0];
        cs_n1_reg  <= cs_next[1];
        sh1_reg    <= sh1_next;
        div1_reg   <= div1_next;
        left1_reg  <= win0_reg.left_ok;
        right1_reg <= win0_reg.right_ok;
        tag1_reg   <= win0_reg.tag;
        if (v1_reg)
        begin
            prev_cs_reg <= cs_c1_reg;
        end
        x2_reg    <= x2_next;
        div2_reg  <= div1_reg;
        tag2_reg  <= tag1_reg;
        prod3_reg <= prod3_next;
        tag3_reg  <= tag2_reg;
    end

    assign res_valid    = v3_reg;
    assign res.smoothed = HEIGHT_W'(prod3_reg[PW-1:KSH]);
    assign res.tag      = tag3_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/box_mean_filter_3x3.sv =====
`default_nettype none

// 3x3 mean filter over a square map of map_size x map_size heights sent in raster
// order. Takes one word per cycle (sample or flush) while fewer than 8 results are
// in flight or queued; a result is released by the word holding its lower-right
// neighbour, so it trails its own height by about one row and one pixel.
// Send flush words after the frame to drain the last results. Heights sit in three
// row buffers of MAX_SIZE words with two read ports each; each word releases at most
// one result, and a bypass covers a height read in the cycle it is written.
// Writing map_size restarts the frame; no clearing pass is needed after reset.
module box_mean_filter_3x3
    import bmf_pkg::*;
#(
    parameter int MAX_SIZE    = 64,
    parameter int HEIGHT_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                mode,
    input  logic [HEIGHT_W-1:0] height_in,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [HEIGHT_W-1:0] smoothed,
    output logic [POS_W-1:0]    out_row,
    output logic [POS_W-1:0]    out_col,
    output logic                frame_last,
    input  logic                cfg_wr_en,
    input  logic [SIZE_W-1:0]   cfg_wr_data
);

    localparam int CW         = $clog2(MAX_SIZE + 1);
    localparam int AW         = $clog2(MAX_SIZE);
    localparam int DW         = (HEIGHT_BITS < HEIGHT_W) ? HEIGHT_BITS : HEIGHT_W;
    localparam int RESET_SIZE = (MAX_SIZE < SIZE_RESET) ? MAX_SIZE : SIZE_RESET;

    logic [CW-1:0] size_reg,   size_next;
    logic [CW-1:0] wr_row_reg, wr_row_next;
    logic [CW-1:0] wr_col_reg, wr_col_next;
    bmf_slot_t     wr_slot_reg, wr_slot_next;
    logic [CW-1:0] em_row_reg, em_row_next;
    logic [CW-1:0] em_col_reg, em_col_next;
    bmf_slot_t     em_slot_reg, em_slot_next;
    logic [OUT_CNT_W-1:0] pend_reg, pend_next;

    logic in_fire;
    logic out_fire;
    logic [CW-1:0] size_m1;
    logic do_write;
    logic wcol_wrap;
    logic [CW-1:0] n_row;
    logic [CW-1:0] n_col;
    logic [CW-1:0] need_row;
    logic [CW-1:0] need_col;
    logic avail;
    logic emit;
    logic is_last;
    bmf_win_t win;

    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid && out_ready;
    assign in_ready  = (pend_reg < OUT_CNT_W'(OUT_DEPTH));
    assign size_m1   = size_reg - CW'(1);
    assign do_write  = in_fire && (mode != MODE_FLUSH) && (wr_row_reg != size_reg);
    assign wcol_wrap = (wr_col_reg == size_m1);

    // write position after this word
    always_comb
    begin
        n_row = wr_row_reg;
        n_col = wr_col_reg;
        if (do_write)
        begin
            if (wcol_wrap)
            begin
                n_row = wr_row_reg + CW'(1);
                n_col = '0;
            end
            else
            begin
                n_col = wr_col_reg + CW'(1);
            end
        end
    end

    // lower-right neighbour of the next result
    assign need_row = (em_row_reg == size_m1) ? em_row_reg : em_row_reg + CW'(1);
    assign need_col = (em_col_reg == size_m1) ? em_col_reg : em_col_reg + CW'(1);
    assign avail    = (need_row < n_row) || ((need_row == n_row) && (need_col < n_col));
    assign emit     = in_fire && avail;
    assign is_last  = (em_row_reg == size_m1) && (em_col_reg == size_m1);

    always_comb
    begin
        win.top_ok   = (em_row_reg != '0);
        win.bot_ok   = (em_row_reg != size_m1);
        win.left_ok  = (em_col_reg != '0);
        win.right_ok = (em_col_reg != size_m1);
        win.slot_top = bmf_slot_prev(em_slot_reg);
        win.slot_mid = em_slot_reg;
        win.slot_bot = bmf_slot_next(em_slot_reg);
        win.tag.row  = POS_W'(em_row_reg);
        win.tag.col  = POS_W'(em_col_reg);
        win.tag.last = is_last;
    end

    always_comb
    begin
        size_next    = size_reg;
        wr_row_next  = n_row;
        wr_col_next  = n_col;
        wr_slot_next = (do_write && wcol_wrap) ? bmf_slot_next(wr_slot_reg) : wr_slot_reg;
        em_row_next  = em_row_reg;
        em_col_next  = em_col_reg;
        em_slot_next = em_slot_reg;
        if (emit)
        begin
            if (em_col_reg == size_m1)
            begin
                em_col_next  = '0;
                em_row_next  = em_row_reg + CW'(1);
                em_slot_next = bmf_slot_next(em_slot_reg);
            end
            else
            begin
                em_col_next = em_col_reg + CW'(1);
            end
        end
        if ((emit && is_last) || cfg_wr_en)
        begin
            wr_row_next  = '0;
            wr_col_next  = '0;
            wr_slot_next = SLOT_FIRST;
            em_row_next  = '0;
            em_col_next  = '0;
            em_slot_next = SLOT_FIRST;
        end
        if (cfg_wr_en)
        begin
            if (cfg_wr_data == '0)
            begin
                size_next = CW'(1);
            end
            else if (32'(cfg_wr_data) > MAX_SIZE)
            begin
                size_next = CW'(MAX_SIZE);
            end
            else
            begin
                size_next = CW'(cfg_wr_data);
            end
        end
    end

    always_comb
    begin
        pend_next = pend_reg;
        if (emit && !out_fire)
        begin
            pend_next = pend_reg + OUT_CNT_W'(1);
        end
        else if (!emit && out_fire)
        begin
            pend_next = pend_reg - OUT_CNT_W'(1);
        end
    end

    logic        dp_res_valid;
    bmf_result_t dp_res;

    bmf_datapath #(
        .MAX_SIZE (MAX_SIZE),
        .DW       (DW)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (do_write),
        .wr_slot   (wr_slot_reg),
        .wr_addr   (AW'(wr_col_reg)),
        .wr_data   (DW'(height_in)),
        .rd_col    (AW'(em_col_reg)),
        .emit_en   (emit),
        .win       (win),
        .res_valid (dp_res_valid),
        .res       (dp_res)
    );

    // result queue
    bmf_result_t          fifo_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] wptr_reg, wptr_next;
    logic [OUT_PTR_W-1:0] rptr_reg, rptr_next;
    logic [OUT_CNT_W-1:0] fifo_cnt_reg, fifo_cnt_next;

    always_comb
    begin
        wptr_next     = dp_res_valid ? wptr_reg + OUT_PTR_W'(1) : wptr_reg;
        rptr_next     = out_fire ? rptr_reg + OUT_PTR_W'(1) : rptr_reg;
        fifo_cnt_next = fifo_cnt_reg;
        if (dp_res_valid && !out_fire)
        begin
            fifo_cnt_next = fifo_cnt_reg + OUT_CNT_W'(1);
        end
        else if (!dp_res_valid && out_fire)
        begin
            fifo_cnt_next = fifo_cnt_reg - OUT_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_res_valid)
        begin
            fifo_reg[wptr_reg] <= dp_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg     <= CW'(RESET_SIZE);
            wr_row_reg   <= '0;
            wr_col_reg   <= '0;
            wr_slot_reg  <= SLOT_FIRST;
            em_row_reg   <= '0;
            em_col_reg   <= '0;
            em_slot_reg  <= SLOT_FIRST;
            pend_reg     <= '0;
            wptr_reg     <= '0;
            rptr_reg     <= '0;
            fifo_cnt_reg <= '0;
        end
        else
        begin
            size_reg     <= size_next;
            wr_row_reg   <= wr_row_next;
            wr_col_reg   <= wr_col_next;
            wr_slot_reg  <= wr_slot_next;
            em_row_reg   <= em_row_next;
            em_col_reg   <= em_col_next;
            em_slot_reg  <= em_slot_next;
            pend_reg     <= pend_next;
            wptr_reg     <= wptr_next;
            rptr_reg     <= rptr_next;
            fifo_cnt_reg <= fifo_cnt_next;
        end
    end

    assign out_valid  = (fifo_cnt_reg != '0);
    assign smoothed   = fifo_reg[rptr_reg].smoothed;
    assign out_row    = fifo_reg[rptr_reg].tag.row;
    assign out_col    = fifo_reg[rptr_reg].tag.col;
    assign frame_last = fifo_reg[rptr_reg].tag.last;

`ifndef NO_ASSERTIONS
    a_fifo_room: assert property (@(posedge clk) disable iff (!rst_n)
        (dp_res_valid && !out_fire) |-> (fifo_cnt_reg != OUT_CNT_W'(OUT_DEPTH)))
        else $error("result queue overflow");

    a_pend_covers_queue: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg >= fifo_cnt_reg)
        else $error("pending count below queue fill");

    a_wr_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_col_reg < size_reg) && (wr_row_reg <= size_reg))
        else $error("write position outside map");

    a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr_en |=> (wr_row_reg == '0) && (wr_col_reg == '0) && (em_row_reg == '0)
                      && (em_col_reg == '0))
        else $error("frame not restarted after size write");
`endif

endmodule

`default_nettype wire
